FILE: hdl/lmt_pkg.sv
// lmt_pkg: shared constants, types and register codes of the local mean threshold
// depends on nothing; used by every module under hdl
`timescale 1ns / 1ps
`default_nettype none

package lmt_pkg;

	// window geometry
	localparam int RADIUS    = 2;
	localparam int MAX_WIDTH = 1024;
	localparam int SIDE      = 2 * RADIUS + 1;
	localparam int AREA      = SIDE * SIDE;

	// field and register widths
	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;

	// derived widths
	localparam int XW       = $clog2(MAX_WIDTH);
	localparam int ROW_BITS = 2 * RADIUS * PIX_W;
	localparam int COL_BITS = SIDE * PIX_W;
	localparam int CS_W     = $clog2(SIDE * 255 + 1);
	localparam int TOT_W    = $clog2(AREA * 255 + 1);

	// reset geometry: 640 x 480, width clamped to the line store
	localparam int RESET_WIDTH  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int RESET_HEIGHT = 480;

	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	// position tag that travels with each request
	typedef struct packed {
		logic first_col;
		logic emit;
		logic frame_last;
	} pos_t;

	// one thresholded result
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
	} res_t;

endpackage

`default_nettype wire

FILE: hdl/lmt_line_store.sv
// lmt_line_store: line store memory holding the previous 2*RADIUS rows per column,
// read-modify-write with forwarding; depends on lmt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lmt_line_store (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          accept,
	input  wire logic [lmt_pkg::XW-1:0]        addr,
	input  wire logic [lmt_pkg::PIX_W-1:0]     pixel,
	input  wire lmt_pkg::pos_t                 pos,
	output logic                               valid_s1,
	output lmt_pkg::pos_t                      pos_s1,
	output logic [lmt_pkg::COL_BITS-1:0]       col_s1
);

	logic [lmt_pkg::ROW_BITS-1:0] mem [lmt_pkg::MAX_WIDTH];
	logic [lmt_pkg::ROW_BITS-1:0] rd_s1;
	logic [lmt_pkg::XW-1:0]       addr_s1;
	logic [lmt_pkg::PIX_W-1:0]    pixel_s1;
	logic [lmt_pkg::ROW_BITS-1:0] wdata;
	logic                         fwd;

	// newest pixel in the low byte, row y-k in byte k
	assign col_s1 = {rd_s1, pixel_s1};
	// oldest row drops out on write-back
	assign wdata  = col_s1[lmt_pkg::ROW_BITS-1:0];
	assign fwd    = valid_s1 && (addr_s1 == addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en && accept) begin
			addr_s1  <= addr;
			pixel_s1 <= pixel;
			pos_s1   <= pos;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			mem[addr_s1] <= wdata;
		end
		if (en && accept) begin
			rd_s1 <= fwd ? wdata : mem[addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/lmt_window.sv
// lmt_window: column sums, sliding window total, centre delay line and threshold compare
// depends on lmt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lmt_window (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        valid_s1,
	input  wire lmt_pkg::pos_t               pos_s1,
	input  wire logic [lmt_pkg::COL_BITS-1:0] col_s1,
	output logic                             res_valid,
	output lmt_pkg::res_t                    res
);

	logic [lmt_pkg::CS_W-1:0]  cs;
	logic [lmt_pkg::CS_W-1:0]  cs_s2;
	logic [lmt_pkg::PIX_W-1:0] ctr_q [lmt_pkg::RADIUS];
	logic [lmt_pkg::PIX_W-1:0] center_s2;
	logic [lmt_pkg::PIX_W-1:0] center_s3;
	logic [lmt_pkg::CS_W-1:0]  hist_q [lmt_pkg::SIDE];
	logic [lmt_pkg::TOT_W-1:0] total_q;
	logic [lmt_pkg::TOT_W-1:0] thresh;
	lmt_pkg::pos_t             pos_s2;
	lmt_pkg::pos_t             pos_s3;
	logic                      valid_s2;
	logic                      valid_s3;

	// sum of one column over SIDE rows
	always_comb begin
		cs = '0;
		for (int k = 0; k < lmt_pkg::SIDE; k++) begin
			cs = cs + lmt_pkg::CS_W'(col_s1[k*lmt_pkg::PIX_W +: lmt_pkg::PIX_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 2: column sum, and centre taken RADIUS columns back
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			cs_s2     <= cs;
			pos_s2    <= pos_s1;
			center_s2 <= ctr_q[lmt_pkg::RADIUS-1];
			ctr_q[0]  <= col_s1[lmt_pkg::RADIUS*lmt_pkg::PIX_W +: lmt_pkg::PIX_W];
			for (int i = 1; i < lmt_pkg::RADIUS; i++) begin
				ctr_q[i] <= ctr_q[i-1];
			end
		end
	end

	// stage 3: sliding total over the last SIDE column sums, restarted per row
	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			center_s3 <= center_s2;
			pos_s3    <= pos_s2;
			hist_q[0] <= cs_s2;
			if (pos_s2.first_col) begin
				total_q <= lmt_pkg::TOT_W'(cs_s2);
				for (int i = 1; i < lmt_pkg::SIDE; i++) begin
					hist_q[i] <= '0;
				end
			end else begin
				total_q <= total_q - lmt_pkg::TOT_W'(hist_q[lmt_pkg::SIDE-1])
					+ lmt_pkg::TOT_W'(cs_s2);
				for (int i = 1; i < lmt_pkg::SIDE; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
		end
	end

	// mean >= centre, done as total >= centre * area
	assign thresh    = lmt_pkg::TOT_W'(center_s3) * lmt_pkg::TOT_W'(lmt_pkg::AREA);
	assign res_valid = valid_s3 && pos_s3.emit;
	assign res.pix   = (total_q >= thresh) ? lmt_pkg::PIX_WHITE : lmt_pkg::PIX_BLACK;
	assign res.last  = pos_s3.frame_last;

endmodule

`default_nettype wire

FILE: hdl/lmt_out_buf.sv
// lmt_out_buf: output register plus skid entry, gives the pipeline advance enable
// depends on lmt_pkg
`timescale 1ns / 1ps
`default_nettype none

module lmt_out_buf (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     res_valid,
	input  wire lmt_pkg::res_t            res,
	output logic                          en,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [lmt_pkg::PIX_W-1:0]     out_pixel,
	output logic                          frame_end
);

	logic          out_valid_q;
	logic          skid_valid_q;
	lmt_pkg::res_t out_q;
	lmt_pkg::res_t skid_q;

	assign en        = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_pixel = out_q.pix;
	assign frame_end = out_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!skid_valid_q) begin
			if (res_valid && out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end else if (out_ready) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			if (res_valid && out_valid_q && !out_ready) begin
				skid_q <= res;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (out_ready) begin
			out_q <= skid_q;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/local_mean_threshold.sv
// local_mean_threshold: adaptive threshold of a raster pixel stream against the
// mean of a square window; uses lmt_pkg, lmt_line_store, lmt_window, lmt_out_buf
//
//   channel   handshake              payload                 role
//   in        in_valid / in_ready    pixel                   raster pixel request
//   out       out_valid / out_ready  out_pixel, frame_end    thresholded request
//   cfg       cfg_write              cfg_index, cfg_data     register write, no wait
//
// one pixel per clock sustained while the output does not stall
// the line store is one memory word per column (previous 2*RADIUS rows), read and
// written back for each pixel taken, with forwarding when the same column comes round again
// reset gives 640 x 480 and a fresh frame; the line store needs no clearing
// a stalled output parks one result in the skid entry; in_ready then drops for the
// whole pipeline and comes back the cycle after the parked result moves on
`timescale 1ns / 1ps
`default_nettype none

module local_mean_threshold (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// pixel input
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [lmt_pkg::PIX_W-1:0]         pixel,
	// result output
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [lmt_pkg::PIX_W-1:0]              out_pixel,
	output logic                                   frame_end,
	// configuration writes
	input  wire logic                              cfg_write,
	input  wire logic [lmt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lmt_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic                             en;
	logic                             accept;
	// position of the next pixel
	logic [lmt_pkg::XW-1:0]           x_q;
	logic [lmt_pkg::HEIGHT_W-1:0]     y_q;
	// last column and last row of the frame, already clamped
	logic [lmt_pkg::XW-1:0]           last_x_q;
	logic [lmt_pkg::HEIGHT_W-1:0]     last_y_q;
	logic [lmt_pkg::XW-1:0]           new_last_x;
	logic [lmt_pkg::HEIGHT_W-1:0]     new_last_y;
	logic [lmt_pkg::WIDTH_W-1:0]      wr_width;
	logic [lmt_pkg::HEIGHT_W-1:0]     wr_height;
	lmt_pkg::pos_t                    pos;
	lmt_pkg::pos_t                    pos_s1;
	logic                             valid_s1;
	logic [lmt_pkg::COL_BITS-1:0]     col_s1;
	logic                             res_valid;
	lmt_pkg::res_t                    res;

	assign in_ready = en;
	assign accept   = in_valid && en;

	// width: zero acts as one, anything above the line store is clamped
	assign wr_width  = cfg_data[lmt_pkg::WIDTH_W-1:0];
	assign wr_height = cfg_data[lmt_pkg::HEIGHT_W-1:0];

	always_comb begin
		if (wr_width == '0) begin
			new_last_x = '0;
		end else if (32'(wr_width) > lmt_pkg::MAX_WIDTH) begin
			new_last_x = lmt_pkg::XW'(lmt_pkg::MAX_WIDTH - 1);
		end else begin
			new_last_x = lmt_pkg::XW'(wr_width - 1'b1);
		end
	end

	// height zero acts as one
	assign new_last_y = (wr_height == '0) ? '0 : wr_height - 1'b1;

	// tag for this pixel: row restart, window fully inside, last result of the frame
	assign pos.first_col  = (x_q == '0);
	assign pos.emit       = (32'(x_q) >= 2 * lmt_pkg::RADIUS)
		&& (32'(y_q) >= 2 * lmt_pkg::RADIUS);
	assign pos.frame_last = (x_q == last_x_q) && (y_q == last_y_q);

	// geometry registers and raster counters; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= lmt_pkg::XW'(lmt_pkg::RESET_WIDTH - 1);
			last_y_q <= lmt_pkg::HEIGHT_W'(lmt_pkg::RESET_HEIGHT - 1);
			x_q      <= '0;
			y_q      <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				lmt_pkg::CFG_IMAGE_WIDTH: begin
					last_x_q <= new_last_x;
				end
				lmt_pkg::CFG_IMAGE_HEIGHT: begin
					last_y_q <= new_last_y;
				end
				default: begin
				end
			endcase
			x_q <= '0;
			y_q <= '0;
		end else if (accept) begin
			if (x_q == last_x_q) begin
				x_q <= '0;
				y_q <= (y_q == last_y_q) ? '0 : y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	// column read-modify-write of the line store
	lmt_line_store u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.accept   (accept),
		.addr     (x_q),
		.pixel    (pixel),
		.pos      (pos),
		.valid_s1 (valid_s1),
		.pos_s1   (pos_s1),
		.col_s1   (col_s1)
	);

	// window sums and the threshold decision
	lmt_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_s1  (valid_s1),
		.pos_s1    (pos_s1),
		.col_s1    (col_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register with skid entry
	lmt_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.en        (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_pixel (out_pixel),
		.frame_end (frame_end)
	);

endmodule

`default_nettype wire
